### src/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg: shared types and constants of the XOR-checked frame receiver
// Status codes, framing characters, the job descriptor that goes from the
// front end to the back end, and small control structs.
// ----------------------------------------------------------------------------
package xcfr_pkg;

   // frame store depth per bank, default and upper limit
   localparam int FRAME_BYTES_DEF = 64;
   localparam int FRAME_BYTES_MAX = 64;
   localparam int JOB_CNT_W       = $clog2(FRAME_BYTES_MAX);

   // framing characters
   localparam logic [7:0] OPEN_MARK   = 8'h23;
   localparam logic [7:0] CLOSE_MARK  = 8'h25;
   localparam logic [7:0] NIBBLE_MASK = 8'h0f;

   typedef logic [2:0] status_type;

   // frame status codes
   localparam status_type ST_GOOD     = 3'd0;
   localparam status_type ST_OVERRUN  = 3'd1;
   localparam status_type ST_SENDER   = 3'd2;
   localparam status_type ST_CHECKSUM = 3'd3;
   localparam status_type ST_SHORT    = 3'd4;

   // register indexes
   localparam logic CSR_EXPECTED_SENDER = 1'b0;
   localparam logic CSR_ACCEPT_ANY      = 1'b1;

   // reset value of the expected sender id
   localparam logic [7:0] EXPECTED_SENDER_RST = 8'd75;

   typedef struct packed {
      logic [7:0] expected_sender;
      logic       accept_any_sender;
   } cfg_type;

   // one closed frame, waiting for the back end
   typedef struct packed {
      status_type           status;
      logic [7:0]           sender;
      logic [JOB_CNT_W-1:0] count;   // payload bytes of a good frame
      logic                 bank;    // buffer bank holding the frame
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } jobq_stat_type;

endpackage

### src/xcfr_buf.sv
// ----------------------------------------------------------------------------
// xcfr_buf: two-bank frame buffer
// One write port for the front end, one registered read port for the back
// end. Each bank holds one frame.
// ----------------------------------------------------------------------------
module xcfr_buf #(
   parameter int ADDR_W = 6
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W:0]   wr_addr,
   input  logic [7:0]        wr_data,
   input  logic [ADDR_W:0]   rd_addr,
   output logic [7:0]        rd_data
);

   localparam int DEPTH = 2 ** (ADDR_W + 1);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/xcfr_jobq.sv
// ----------------------------------------------------------------------------
// xcfr_jobq: two-entry job queue
// Holds closed frames between the front end and the back end. The head
// stays until the back end loads its last beat into its output register.
// ----------------------------------------------------------------------------
module xcfr_jobq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  xcfr_pkg::job_type        push_job,
   input  logic                     pop,
   output xcfr_pkg::job_type        head_job,
   output xcfr_pkg::jobq_stat_type  stat
);
   import xcfr_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 2'd1;
         2'b01:   cnt_in = cnt_ff - 2'd1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job   = entry_ff[rd_ptr_ff];
   assign stat.full  = (cnt_ff == 2'd2);
   assign stat.empty = (cnt_ff == 2'd0);

endmodule

### src/xcfr_front.sv
// ----------------------------------------------------------------------------
// xcfr_front: receive front end
// Accepts bytes, tracks framing, writes frame bytes into the current
// buffer bank and, on the closing character, checks the frame and queues
// a job for the back end.
// ----------------------------------------------------------------------------
module xcfr_front #(
   parameter int FRAME_BYTES = 64,
   parameter int ADDR_W      = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic [7:0]               req_rx_byte,
   output logic                     req_stall,
   input  xcfr_pkg::cfg_type        cfg,
   input  xcfr_pkg::jobq_stat_type  q_stat,
   output logic                     mem_wr_en,
   output logic [ADDR_W:0]          mem_wr_addr,
   output logic [7:0]               mem_wr_data,
   output logic                     job_push,
   output xcfr_pkg::job_type        job
);
   import xcfr_pkg::*;

   localparam logic [ADDR_W-1:0] FILL_LIMIT = ADDR_W'(FRAME_BYTES - 1);
   localparam logic [ADDR_W-1:0] MIN_FILL   = ADDR_W'(3);

   logic              in_frame_ff, in_frame_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              overrun_ff, overrun_in;
   logic [7:0]        xor_ff, xor_in;
   logic [7:0]        sender_ff, sender_in;
   logic [7:0]        last1_ff, last1_in;   // most recent stored byte
   logic [7:0]        last2_ff, last2_in;   // the one before it
   logic              bank_ff, bank_in;

   logic       accept;
   logic       is_open;
   logic       is_close;
   logic       is_data;
   logic       store;
   logic [7:0] chk_sum;
   logic [7:0] chk_ref;
   status_type status;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;
   assign is_open   = accept && (req_rx_byte == OPEN_MARK);
   assign is_close  = accept && in_frame_ff && (req_rx_byte == CLOSE_MARK);
   assign is_data   = accept && in_frame_ff && (req_rx_byte != 8'd0) &&
                      (req_rx_byte != OPEN_MARK) && (req_rx_byte != CLOSE_MARK);
   assign store     = is_data && (fill_ff < FILL_LIMIT);

   // frame check, first failing check wins
   assign chk_sum = xor_ff ^ last1_ff ^ last2_ff;
   assign chk_ref = (last2_ff & NIBBLE_MASK) | ((last1_ff & NIBBLE_MASK) << 4);

   always_comb begin
      priority if (overrun_ff) begin
         status = ST_OVERRUN;
      end else if (fill_ff < MIN_FILL) begin
         status = ST_SHORT;
      end else if (!cfg.accept_any_sender && (sender_ff != cfg.expected_sender)) begin
         status = ST_SENDER;
      end else if (chk_sum != chk_ref) begin
         status = ST_CHECKSUM;
      end else begin
         status = ST_GOOD;
      end
   end

   // job for the back end
   assign job_push      = is_close;
   assign job.status    = status;
   assign job.sender    = (fill_ff != '0) ? sender_ff : 8'd0;
   assign job.count     = (fill_ff > MIN_FILL) ? JOB_CNT_W'(fill_ff - MIN_FILL)
                                               : JOB_CNT_W'(0);
   assign job.bank      = bank_ff;

   // buffer write
   assign mem_wr_en   = store;
   assign mem_wr_addr = {bank_ff, fill_ff};
   assign mem_wr_data = req_rx_byte;

   // framing state
   always_comb begin
      in_frame_in = in_frame_ff;
      fill_in     = fill_ff;
      overrun_in  = overrun_ff;
      xor_in      = xor_ff;
      sender_in   = sender_ff;
      last1_in    = last1_ff;
      last2_in    = last2_ff;
      bank_in     = bank_ff;
      priority if (is_open) begin
         in_frame_in = 1'b1;
         fill_in     = '0;
         overrun_in  = 1'b0;
         xor_in      = 8'd0;
      end else if (is_close) begin
         in_frame_in = 1'b0;
         bank_in     = ~bank_ff;
      end else if (store) begin
         if (fill_ff == '0) begin
            sender_in = req_rx_byte;
         end else begin
            xor_in = xor_ff ^ req_rx_byte;
         end
         last1_in = req_rx_byte;
         last2_in = last1_ff;
         fill_in  = fill_ff + ADDR_W'(1);
      end else if (is_data) begin
         overrun_in = 1'b1;
      end else begin
         // no beat, or an ignored byte: framing holds
         in_frame_in = in_frame_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         fill_ff     <= '0;
         overrun_ff  <= 1'b0;
         xor_ff      <= 8'd0;
         bank_ff     <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         fill_ff     <= fill_in;
         overrun_ff  <= overrun_in;
         xor_ff      <= xor_in;
         bank_ff     <= bank_in;
      end
   end

   // data registers
   always_ff @(posedge clock) begin
      sender_ff <= sender_in;
      last1_ff  <= last1_in;
      last2_ff  <= last2_in;
   end

endmodule

### src/xcfr_back.sv
// ----------------------------------------------------------------------------
// xcfr_back: result back end
// Takes the job at the head of the queue and sends its result beats:
// one status beat for a bad or empty frame, else one beat per payload
// byte read from the buffer.
// ----------------------------------------------------------------------------
module xcfr_back #(
   parameter int ADDR_W = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  xcfr_pkg::job_type        job,
   input  xcfr_pkg::jobq_stat_type  q_stat,
   output logic                     job_pop,
   output logic [ADDR_W:0]          mem_rd_addr,
   input  logic [7:0]               mem_rd_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_frame_status,
   output logic [7:0]               rsp_sender_id,
   output logic [7:0]               rsp_payload_byte,
   output logic                     rsp_byte_valid,
   output logic                     rsp_last_result
);
   import xcfr_pkg::*;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_READ = 2'd1;
   localparam logic [1:0] B_SEND = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [7:0]        rsp_sender_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_bvalid_ff;
   logic              rsp_last_ff;

   logic       out_free;
   logic       load;
   logic [7:0] ld_byte;
   logic       ld_bvalid;
   logic       ld_last;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign mem_rd_addr = {job.bank, idx_ff};

   // sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      job_pop   = 1'b0;
      load      = 1'b0;
      ld_byte   = 8'd0;
      ld_bvalid = 1'b0;
      ld_last   = 1'b1;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               if ((job.status != ST_GOOD) || (job.count == '0)) begin
                  if (out_free) begin
                     load    = 1'b1;
                     job_pop = 1'b1;
                  end
               end else begin
                  idx_in   = ADDR_W'(1);
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            state_in = B_SEND;
         end
         B_SEND: begin
            if (out_free) begin
               load      = 1'b1;
               ld_byte   = mem_rd_data;
               ld_bvalid = 1'b1;
               ld_last   = (JOB_CNT_W'(idx_ff) == job.count);
               if (ld_last) begin
                  job_pop  = 1'b1;
                  state_in = B_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = B_READ;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      priority if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_status_ff <= job.status;
         rsp_sender_ff <= job.sender;
         rsp_byte_ff   <= ld_byte;
         rsp_bvalid_ff <= ld_bvalid;
         rsp_last_ff   <= ld_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_sender_id    = rsp_sender_ff;
   assign rsp_payload_byte = rsp_byte_ff;
   assign rsp_byte_valid   = rsp_bvalid_ff;
   assign rsp_last_result  = rsp_last_ff;

endmodule

### src/xor_checked_frame_receiver_unit.sv
// A status-only frame's result beat is loaded from the queue head into the output
// register; a frame with payload first passes through the back end's read state.
// Throughput: one received byte per cycle while the input is not stalled; each
// payload beat takes a buffer read, then an output register load, in sequence.
// Input stalls only while two closed frames still wait to be sent.
// Reset: synchronous, clears framing, queue and output state; buffer keeps data.
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_unit: delimited frame receiver, XOR checksum
// Front end frames and checks bytes into a two-bank buffer, a job queue
// decouples it from the back end that sends status and payload beats.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver_unit #(
   parameter int FRAME_BYTES = xcfr_pkg::FRAME_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_frame_status,
   output logic [7:0] rsp_sender_id,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last_result,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wr_data
);
   import xcfr_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_BYTES);

   logic [7:0] exp_sender_ff, exp_sender_in;
   logic       accept_any_ff, accept_any_in;

   cfg_type       cfg;
   jobq_stat_type q_stat;
   job_type       push_job;
   job_type       head_job;
   logic          job_push;
   logic          job_pop;

   logic              mem_wr_en;
   logic [ADDR_W:0]   mem_wr_addr;
   logic [7:0]        mem_wr_data;
   logic [ADDR_W:0]   mem_rd_addr;
   logic [7:0]        mem_rd_data;

   // configuration registers
   always_comb begin
      exp_sender_in = exp_sender_ff;
      accept_any_in = accept_any_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_EXPECTED_SENDER: exp_sender_in = csr_wr_data;
            CSR_ACCEPT_ANY:      accept_any_in = csr_wr_data[0];
            default:             exp_sender_in = exp_sender_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_sender_ff <= EXPECTED_SENDER_RST;
         accept_any_ff <= 1'b0;
      end else begin
         exp_sender_ff <= exp_sender_in;
         accept_any_ff <= accept_any_in;
      end
   end

   assign cfg.expected_sender   = exp_sender_ff;
   assign cfg.accept_any_sender = accept_any_ff;

   // front end
   xcfr_front #(
      .FRAME_BYTES (FRAME_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .cfg         (cfg),
      .q_stat      (q_stat),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .job_push    (job_push),
      .job         (push_job)
   );

   // frame buffer
   xcfr_buf #(
      .ADDR_W (ADDR_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // job queue
   xcfr_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .stat     (q_stat)
   );

   // back end
   xcfr_back #(
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .job              (head_job),
      .q_stat           (q_stat),
      .job_pop          (job_pop),
      .mem_rd_addr      (mem_rd_addr),
      .mem_rd_data      (mem_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_frame_status (rsp_frame_status),
      .rsp_sender_id    (rsp_sender_id),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_result  (rsp_last_result)
   );

endmodule
